// ----- design/assert_macros.svh -----
// assertion macros for the segment translation table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- design/satt_pkg.sv -----
// shared types and constants of the segment translation table
`default_nettype none
package satt_pkg;
  localparam int unsigned SegmentsDef = 16;
  localparam int unsigned AddrW = 64;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_P2D = 2'd1,
    FUNC_D2P = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [AddrW-1:0] query_addr;
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0] xlat_addr;
    logic [AddrW-1:0] seg_base_out;
    logic [1:0]       status;
  } rsp_t;

  // front to back: classified command
  typedef struct packed {
    cmd_t cmd;
    logic is_add;
    logic is_query;
  } fq_t;
endpackage
`default_nettype wire

// ----- design/satt_if.sv -----
// valid/ready channel carrying one item
`default_nettype none
interface satt_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/satt_front.sv -----
// front: accepts items, classifies them, two-entry queue toward the back
`default_nettype none
module satt_front import satt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output fq_t  q_data
);
  fq_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  fq_t        cls;
  logic       push, pop;

  always_comb begin
    cls.cmd      = in_data;
    cls.is_add   = (in_data.func == FUNC_ADD);
    cls.is_query = (in_data.func == FUNC_P2D) || (in_data.func == FUNC_D2P);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule
`default_nettype wire

// ----- design/satt_back.sv -----
// back: segment table, parallel compare, priority pick, output register
`default_nettype none
module satt_back import satt_pkg::*; #(
  parameter int unsigned SEGMENTS = SegmentsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  fq_t  q_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data,
  output logic [$clog2(SEGMENTS+1)-1:0] count_o
);
  localparam int unsigned CW = $clog2(SEGMENTS+1);
  localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  logic [AddrW-1:0] first_r [SEGMENTS];
  logic [AddrW-1:0] last_r  [SEGMENTS];
  logic [AddrW-1:0] off_r   [SEGMENTS];
  logic [CW-1:0]    count_r;

  // stage 1: registered per-segment hit vector
  logic             s1_v_r;
  fq_t              s1_r;
  logic [SEGMENTS-1:0] hit_r;
  logic [SEGMENTS-1:0] hit_nxt;

  logic             ov_r;
  rsp_t             od_r;
  rsp_t             od_nxt;

  logic             s1_go, take;
  logic [IW-1:0]    lidx;
  logic             merge;
  logic [AddrW-1:0] packed_sz;

  assign count_o   = count_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  // one item in flight at a time: table updates complete before the next compare
  assign s1_go   = s1_v_r && (!ov_r || out_ready);
  assign q_ready = !s1_v_r && !(ov_r && !out_ready);
  assign take    = q_valid && q_ready;

  always_comb begin
    for (int i = 0; i < SEGMENTS; i++) begin
      if (q_data.cmd.func == FUNC_P2D)
        hit_nxt[i] = (CW'(i) < count_r) && (q_data.cmd.query_addr >= first_r[i]) &&
                     (q_data.cmd.query_addr <= last_r[i]);
      else
        hit_nxt[i] = (CW'(i) < count_r) &&
                     (q_data.cmd.query_addr >= first_r[i] - off_r[i]) &&
                     (q_data.cmd.query_addr <= last_r[i] - off_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (take) s1_v_r <= 1'b1;
    else if (s1_go) s1_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r  <= q_data;
      hit_r <= hit_nxt;
    end
  end

  // add path
  always_comb begin
    lidx      = IW'(count_r - CW'(1));
    merge     = (count_r != '0) && ((last_r[lidx] == '1) ||
                (s1_r.cmd.range_start <= last_r[lidx] + AddrW'(1)));
    packed_sz = (count_r == '0) ? '0 : (last_r[lidx] + AddrW'(1) - off_r[lidx]);
  end

  // priority pick of the first hit
  logic [IW-1:0] sel;
  logic          any;
  always_comb begin
    sel = '0; any = 1'b0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        sel = IW'(i); any = 1'b1;
      end
    end
  end

  // result of the item in stage 1
  always_comb begin
    od_nxt        = '0;
    od_nxt.status = ST_NOT_FOUND;
    if (s1_r.is_add) begin
      if (!merge && (count_r == CW'(SEGMENTS))) od_nxt.status = ST_FULL;
      else od_nxt.status = ST_OK;
    end else if (s1_r.is_query) begin
      if (count_r == '0) od_nxt.status = ST_EMPTY;
      else if (any) begin
        od_nxt.status = ST_OK;
        if (s1_r.cmd.func == FUNC_P2D) begin
          od_nxt.xlat_addr    = s1_r.cmd.query_addr - off_r[sel];
          od_nxt.seg_base_out = off_r[sel];
        end else begin
          od_nxt.xlat_addr = s1_r.cmd.query_addr + off_r[sel];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (s1_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (s1_go && s1_r.is_add && !merge && (count_r != CW'(SEGMENTS)))
        count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) od_r <= od_nxt;
  end

  // table update: grow the last segment or, if the table is not full, append a new one
  always_ff @(posedge clk) begin
    if (s1_go && s1_r.is_add) begin
      if (merge) begin
        if (s1_r.cmd.range_end > last_r[lidx]) last_r[lidx] <= s1_r.cmd.range_end;
      end else if (count_r != CW'(SEGMENTS)) begin
        first_r[IW'(count_r)] <= s1_r.cmd.range_start;
        last_r[IW'(count_r)]  <= s1_r.cmd.range_end;
        off_r[IW'(count_r)]   <= s1_r.cmd.range_start - packed_sz;
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/segment_address_translation_table_unit.sv -----
// top level of the segment address translation table
//
// channel  dir  fields
// in_      in   func, range_start, range_end, query_addr
// out_     out  xlat_addr, seg_base_out, status
//
// an item passes the queue, the compare register and the pick/update (result register) in order;
// the back works on one item at a time: it takes no new item from the queue until the
// current one has left the compare register for the result register
// reset clears the segment count and the queue; table entries are written before use
// a stalled result holds the back, the two-entry queue keeps taking items meanwhile
`default_nettype none
`include "assert_macros.svh"
module segment_address_translation_table_unit import satt_pkg::*; #(
  parameter int unsigned SEGMENTS = SegmentsDef
) (
  input  logic clk,
  input  logic rst_n,
  satt_if.sink   in_ch,
  satt_if.source out_ch
);
  logic q_valid, q_ready;
  fq_t  q_data;
  rsp_t out_d;
  logic [$clog2(SEGMENTS+1)-1:0] count;

  satt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  satt_back #(.SEGMENTS(SEGMENTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_d),
    .count_o(count)
  );
  assign out_ch.data = out_d;

  // segment count never exceeds the table size
  `ASSERT_NEVER(a_count_max, clk, rst_n, count > ($clog2(SEGMENTS+1))'(SEGMENTS))
  // a full-table status only when the table is full
  `ASSERT_IMPL(a_full, clk, rst_n,
    (out_ch.valid && out_d.status == ST_FULL) |-> (count == ($clog2(SEGMENTS+1))'(SEGMENTS)))
  // a stalled result is held
  `ASSERT_IMPL(a_hold, clk, rst_n,
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_d)))
endmodule
`default_nettype wire
